>>> hw/rtl/log_record_framer_crc32_defines.svh
// assertion macros used by the log record framer top level
// no dependencies; expects clk and rst in the including scope
`ifndef LOG_RECORD_FRAMER_CRC32_DEFINES_SVH
`define LOG_RECORD_FRAMER_CRC32_DEFINES_SVH

// same-cycle implication, checked outside reset
`define LRF_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define LRF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/lrf_pkg.sv
// types, constants and the crc-32 byte step for the log record framer
// no dependencies
package lrf_pkg;

  localparam int HEADER_BYTES = 25;
  localparam int CRC_BYTES    = 4;
  localparam int TOTAL_BYTES  = CRC_BYTES + HEADER_BYTES;
  localparam int HDR_BITS     = HEADER_BYTES * 8;
  localparam int SREG_BITS    = TOTAL_BYTES * 8;
  localparam int LEN_W        = 33;

  localparam logic [31:0] CRC_POLY  = 32'hEDB88320;
  localparam logic [31:0] CRC_INIT  = 32'hFFFFFFFF;
  localparam logic [31:0] CRC_XOROUT = 32'hFFFFFFFF;
  localparam logic [7:0]  TOMBSTONE = 8'hFF;

  localparam logic CMD_BEGIN   = 1'b0;
  localparam logic CMD_PAYLOAD = 1'b1;

  typedef enum logic [1:0] {
    FR_READY,
    FR_CRC,
    FR_PUSH
  } front_state_t;

  // one queued unit of work for the back end
  typedef struct packed {
    logic                is_hdr;
    logic [31:0]         crc;
    logic [HDR_BITS-1:0] hdr;
    logic [7:0]          pbyte;
    logic                end_flag;  // payload: record end; header: empty record
    logic                ovr;
  } lrf_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } lrf_qstat_t;

  // reflected crc-32, one byte, lsb first
  function automatic logic [31:0] crc_byte(input logic [31:0] crc_in,
                                           input logic [7:0]  data);
    logic [31:0] c;
    c = crc_in ^ {24'h000000, data};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

>>> hw/rtl/lrf_front.sv
// front end: accepts items, tracks the payload countdown, builds headers
// and their crc one byte per cycle; depends on lrf_pkg
module lrf_front
  import lrf_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [135:0] s_axis_tdata,
  input  logic [0:0]   s_axis_tuser,
  input  lrf_qstat_t   qstat,
  output logic         push,
  output lrf_entry_t   push_entry
);

  front_state_t        state;
  front_state_t        state_next;
  logic [LEN_W-1:0]    remaining;
  logic [31:0]         crc;
  logic [HDR_BITS-1:0] hdr;
  logic [4:0]          cnt;
  logic                empty;
  logic                accept;
  logic [LEN_W-1:0]    len_sum;

  assign accept  = s_axis_tvalid && s_axis_tready;
  assign len_sum = {1'b0, s_axis_tdata[95:64]} + {1'b0, s_axis_tdata[127:96]};

  always_comb begin
    state_next = state;
    case (state)
      FR_READY: begin
        if (accept && s_axis_tuser[0] == CMD_BEGIN) state_next = FR_CRC;
      end
      FR_CRC: begin
        if (cnt == 5'(HEADER_BYTES - 1)) state_next = FR_PUSH;
      end
      FR_PUSH: begin
        if (!qstat.full) state_next = FR_READY;
      end
      default: state_next = FR_READY;
    endcase
  end

  always_comb begin
    s_axis_tready = 1'b0;
    push          = 1'b0;
    push_entry    = '0;
    case (state)
      FR_READY: begin
        s_axis_tready = !qstat.full;
        if (accept && s_axis_tuser[0] == CMD_PAYLOAD) begin
          push                = 1'b1;
          push_entry.pbyte    = s_axis_tdata[135:128];
          push_entry.ovr      = (remaining == '0);
          push_entry.end_flag = (remaining == LEN_W'(1));
        end
      end
      FR_PUSH: begin
        push                = !qstat.full;
        push_entry.is_hdr   = 1'b1;
        push_entry.crc      = crc ^ CRC_XOROUT;
        push_entry.hdr      = hdr;
        push_entry.end_flag = empty;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= FR_READY;
      remaining <= '0;
    end else begin
      state <= state_next;
      if (accept) begin
        if (s_axis_tuser[0] == CMD_BEGIN) begin
          remaining <= len_sum;
        end else if (remaining != '0) begin
          remaining <= remaining - LEN_W'(1);
        end
      end
    end
  end

  // header shifter rotates a full turn while the crc runs
  always_ff @(posedge clk) begin
    if (state == FR_READY && accept && s_axis_tuser[0] == CMD_BEGIN) begin
      hdr   <= {s_axis_tdata[63:0], TOMBSTONE, 32'h0, s_axis_tdata[95:64],
                32'h0, s_axis_tdata[127:96]};
      crc   <= CRC_INIT;
      cnt   <= '0;
      empty <= (len_sum == '0);
    end else if (state == FR_CRC) begin
      crc <= crc_byte(crc, hdr[HDR_BITS-1 -: 8]);
      hdr <= {hdr[HDR_BITS-9:0], hdr[HDR_BITS-1 -: 8]};
      cnt <= cnt + 5'd1;
    end
  end

endmodule

>>> hw/rtl/lrf_queue.sv
// small register fifo between front and back ends
// depends on lrf_pkg
module lrf_queue
  import lrf_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  lrf_entry_t push_entry,
  input  logic       pop,
  output lrf_entry_t head,
  output lrf_qstat_t qstat
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  lrf_entry_t       slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign qstat.full  = (count == CNT_W'(DEPTH));
  assign qstat.empty = (count == '0);
  assign head        = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

endmodule

>>> hw/rtl/lrf_back.sv
// back end: turns queued work into the output byte stream, one byte a cycle
// while the output is ready; depends on lrf_pkg
module lrf_back
  import lrf_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  lrf_entry_t   head,
  input  lrf_qstat_t   qstat,
  output logic         pop,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [7:0]   m_axis_tdata,
  output logic         m_axis_tlast,
  output logic [1:0]   m_axis_tuser
);

  logic                 busy;
  logic [SREG_BITS-1:0] sreg;
  logic [4:0]           cnt;
  logic                 hdr_empty;
  logic                 can_load;
  logic                 hdr_last;

  assign can_load = !m_axis_tvalid || m_axis_tready;
  assign pop      = can_load && !busy && !qstat.empty;
  assign hdr_last = (cnt == 5'(TOTAL_BYTES - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy          <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else if (can_load) begin
      if (busy) begin
        m_axis_tvalid <= 1'b1;
        if (hdr_last) busy <= 1'b0;
      end else if (!qstat.empty) begin
        m_axis_tvalid <= 1'b1;
        busy          <= head.is_hdr;
      end else begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (can_load) begin
      if (busy) begin
        m_axis_tdata <= sreg[SREG_BITS-1 -: 8];
        m_axis_tlast <= hdr_last;
        m_axis_tuser <= {1'b0, hdr_last && hdr_empty};
        sreg         <= {sreg[SREG_BITS-9:0], 8'h00};
        cnt          <= cnt + 5'd1;
      end else if (head.is_hdr) begin
        m_axis_tdata <= head.crc[31:24];
        m_axis_tlast <= 1'b0;
        m_axis_tuser <= 2'b00;
        sreg         <= {head.crc[23:0], head.hdr, 8'h00};
        cnt          <= 5'd1;
        hdr_empty    <= head.end_flag;
      end else begin
        m_axis_tdata <= head.pbyte;
        m_axis_tlast <= 1'b1;
        m_axis_tuser <= {head.ovr, head.end_flag};
      end
    end
  end

endmodule

>>> hw/rtl/log_record_framer_crc32.sv
// log record framer: begin items become a crc-protected 29-byte record head,
// payload items pass through with end-of-record and overrun flags.
// A payload transfer becomes one byte out. A begin transfer holds the input
// side while the front end runs the crc-32 over the 25 header bytes at one
// byte per cycle, then the back end sends its 29 bytes at one per cycle
// while the output is ready; the next header's crc runs while the current
// record streams out, so back-to-back records keep the output busy.
// Payload bytes behind a header are queued, up to the queue depth, while the header is sent.
// depends on lrf_pkg, lrf_front, lrf_queue, lrf_back and the defines header
`include "log_record_framer_crc32_defines.svh"

module log_record_framer_crc32
  import lrf_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // [63:0] stamp_seconds, [95:64] key_length, [127:96] value_length,
  // [135:128] payload_byte
  input  logic [135:0] s_axis_tdata,
  // [0] cmd
  input  logic [0:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [7:0] out_byte
  output logic [7:0]   m_axis_tdata,
  output logic         m_axis_tlast,   // run_last
  // [0] record_end, [1] overrun
  output logic [1:0]   m_axis_tuser
);

  lrf_qstat_t qstat;
  lrf_entry_t push_entry;
  lrf_entry_t head;
  logic       push;
  logic       pop;

  // front end: countdown, header build, crc
  lrf_front u_front (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .qstat         (qstat),
    .push          (push),
    .push_entry    (push_entry)
  );

  // decouples the crc engine from output back-pressure
  lrf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .qstat      (qstat)
  );

  // back end: byte serializer with registered output
  lrf_back u_back (
    .clk           (clk),
    .rst           (rst),
    .head          (head),
    .qstat         (qstat),
    .pop           (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  // queue must never take an entry while full
  `LRF_ASSERT_NOW(a_no_push_full, push, !qstat.full, "push into full queue")
  // record end and overrun are exclusive and only on a run's last byte
  `LRF_ASSERT_NOW(a_flags_last, m_axis_tvalid && (m_axis_tuser != 2'b00),
    m_axis_tlast && (m_axis_tuser != 2'b11), "bad record_end/overrun flags")
  // a begin transfer holds off input while its crc runs
  `LRF_ASSERT_NEXT(a_begin_stalls,
    s_axis_tvalid && s_axis_tready && (s_axis_tuser[0] == CMD_BEGIN),
    !s_axis_tready, "input taken during header crc")

endmodule
